// ----- rtl/vdft_pkg.sv -----
// Shared types and constants of the video DMA frame timer.
// Used by vdft_step and video_dma_frame_timer; depends on nothing else.
package vdft_pkg;

   localparam int OP_W     = 2;
   localparam int CYC_W    = 6;
   localparam int BUDGET_W = 16;
   localparam int LINE_W   = 9;
   localparam int ROW_W    = 7;
   localparam int WIDE_W   = 18;

   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
   localparam logic [OP_W-1:0] OP_START   = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP    = 2'd2;

   typedef enum logic [2:0] {
      PH_OFF,
      PH_ARMED,
      PH_PRE,
      PH_FETCH,
      PH_BLANK_A,
      PH_BLANK_B
   } phase_type;

   typedef struct packed {
      phase_type                   phase;
      logic signed [BUDGET_W-1:0]  budget;
      logic [LINE_W-1:0]           line;
      logic                        dma;
   } timer_state_type;

   typedef struct packed {
      logic              irq;
      logic              fetch;
      logic [ROW_W-1:0]  row;
      logic              dma;
   } step_result_type;

   // Clamp a widened budget value back into the signed 16-bit range.
   function automatic logic signed [BUDGET_W-1:0] sat_budget(
      input logic signed [WIDE_W-1:0] v);
      logic signed [BUDGET_W-1:0] r;
      if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else begin
         r = v[BUDGET_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(
      input logic signed [BUDGET_W-1:0] b);
      return $signed({{(WIDE_W-BUDGET_W){b[BUDGET_W-1]}}, b});
   endfunction

endpackage

// ----- rtl/vdft_step.sv -----
// Next-state and result logic of the frame timer for one request.
// Purely combinational; depends on vdft_pkg.
module vdft_step #(
   parameter int COLUMN_CYCLES = 14,
   parameter int DISPLAY_ROWS  = 128,
   parameter int FRAME_LINES   = 256,
   parameter int FETCH_CYCLES  = 8
) (
   input  logic [vdft_pkg::OP_W-1:0]  op,
   input  logic [vdft_pkg::CYC_W-1:0] cycles,
   input  vdft_pkg::timer_state_type  cur,
   output vdft_pkg::timer_state_type  nxt,
   output vdft_pkg::step_result_type  res
);
   import vdft_pkg::*;

   localparam logic signed [WIDE_W-1:0] COL_ADD   = WIDE_W'(COLUMN_CYCLES);
   localparam logic signed [WIDE_W-1:0] FETCH_ADD = WIDE_W'(COLUMN_CYCLES - FETCH_CYCLES);
   localparam logic signed [WIDE_W-1:0] BLANK_ADD = WIDE_W'(2 * COLUMN_CYCLES);
   localparam logic [LINE_W-1:0]        DISP_END  = LINE_W'(DISPLAY_ROWS);
   localparam logic [LINE_W-1:0]        FRAME_END = LINE_W'(FRAME_LINES);

   logic signed [WIDE_W-1:0]   cyc_wide;
   logic signed [BUDGET_W-1:0] arm_budget;
   logic signed [BUDGET_W-1:0] spent;
   logic signed [BUDGET_W-1:0] spent_col;
   logic signed [BUDGET_W-1:0] spent_fetch;
   logic signed [BUDGET_W-1:0] spent_blank;
   logic [LINE_W-1:0]          line_inc;

   always_comb begin
      cyc_wide    = $signed({{(WIDE_W-CYC_W){1'b0}}, cycles});
      arm_budget  = sat_budget(COL_ADD - cyc_wide);
      spent       = sat_budget(widen(cur.budget) - cyc_wide);
      spent_col   = sat_budget(widen(spent) + COL_ADD);
      spent_fetch = sat_budget(widen(spent) + FETCH_ADD);
      spent_blank = sat_budget(widen(spent_fetch) + BLANK_ADD);
      line_inc    = cur.line + LINE_W'(1);
   end

   always_comb begin
      nxt = cur;
      res = '0;
      case (op)
         OP_START: begin
            nxt.phase = PH_ARMED;
         end
         OP_STOP: begin
            nxt.phase = PH_OFF;
         end
         OP_ADVANCE: begin
            case (cur.phase)
               PH_ARMED: begin
                  nxt.budget = arm_budget;
                  nxt.phase  = PH_PRE;
                  nxt.dma    = 1'b1;
                  res.irq    = 1'b1;
               end
               PH_PRE: begin
                  nxt.budget = spent;
                  if (spent[BUDGET_W-1]) begin
                     nxt.line   = '0;
                     nxt.phase  = PH_FETCH;
                     nxt.budget = spent_col;
                  end
               end
               PH_FETCH: begin
                  nxt.budget = spent;
                  if (spent[BUDGET_W-1]) begin
                     res.fetch  = 1'b1;
                     res.row    = cur.line[ROW_W-1:0];
                     nxt.budget = spent_fetch;
                     nxt.line   = line_inc;
                     // last display row done: drop DMA and add the blanking lead-in
                     if (line_inc >= DISP_END) begin
                        nxt.dma    = 1'b0;
                        nxt.budget = spent_blank;
                        nxt.phase  = PH_BLANK_A;
                     end
                  end
               end
               PH_BLANK_A, PH_BLANK_B: begin
                  nxt.budget = spent;
                  if (spent[BUDGET_W-1]) begin
                     nxt.dma    = (cur.phase == PH_BLANK_A);
                     nxt.budget = spent_col;
                     nxt.phase  = (cur.phase == PH_BLANK_A) ? PH_BLANK_B : PH_BLANK_A;
                     nxt.line   = line_inc;
                     if (line_inc >= FRAME_END) begin
                        nxt.phase = PH_ARMED;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      res.dma = nxt.dma;
   end

endmodule

// ----- rtl/video_dma_frame_timer.sv -----
// Top level of the video DMA frame timer: request register, state, response register.
// Depends on vdft_pkg and vdft_step.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------------
//   req     | in  | req_valid/req_stall  | req_op, req_cycles
//   rsp     | out | rsp_valid/rsp_stall  | rsp_irq_pulse, rsp_row_fetch,
//           |     |                      | rsp_fetch_row, rsp_dma_active, rsp_vsync
//
// One request per clock sustained while rsp_stall stays low; each accepted request passes
// through the request register, then the state update into the response register.
// Reset clears the phase to off, the budget and line counter to zero and DMA low.
// A stalled response holds the pipeline; req_stall rises only while the request
// register is full and the response register cannot drain.
module video_dma_frame_timer #(
   parameter int COLUMN_CYCLES = 14,
   parameter int DISPLAY_ROWS  = 128,
   parameter int FRAME_LINES   = 256,
   parameter int FETCH_CYCLES  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vdft_pkg::OP_W-1:0]    req_op,
   input  logic [vdft_pkg::CYC_W-1:0]   req_cycles,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_irq_pulse,
   output logic                         rsp_row_fetch,
   output logic [vdft_pkg::ROW_W-1:0]   rsp_fetch_row,
   output logic                         rsp_dma_active,
   output logic                         rsp_vsync
);
   import vdft_pkg::*;

   logic              in_valid_ff;
   logic [OP_W-1:0]   in_op_ff;
   logic [CYC_W-1:0]  in_cycles_ff;
   timer_state_type   state_ff;
   timer_state_type   state_in;
   step_result_type   result_in;
   step_result_type   result_ff;
   logic              rsp_valid_ff;
   logic              out_ready;
   logic              advance;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   vdft_step #(
      .COLUMN_CYCLES(COLUMN_CYCLES),
      .DISPLAY_ROWS (DISPLAY_ROWS),
      .FRAME_LINES  (FRAME_LINES),
      .FETCH_CYCLES (FETCH_CYCLES)
   ) u_step (
      .op    (in_op_ff),
      .cycles(in_cycles_ff),
      .cur   (state_ff),
      .nxt   (state_in),
      .res   (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_OFF, budget: '0, line: '0, dma: 1'b0};
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= advance;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff     <= req_op;
         in_cycles_ff <= req_cycles;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_irq_pulse  = result_ff.irq;
   assign rsp_row_fetch  = result_ff.fetch;
   assign rsp_fetch_row  = result_ff.row;
   assign rsp_dma_active = result_ff.dma;
   assign rsp_vsync      = !result_ff.dma;

   a_fetch_no_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_fetch |-> !rsp_irq_pulse)
      else $error("row fetch and frame interrupt in the same response");

   a_stop_turns_off: assert property (@(posedge clock) disable iff (reset)
      advance && in_op_ff == OP_STOP |=> state_ff.phase == PH_OFF)
      else $error("stop request did not turn the sequencer off");

   a_dma_while_display: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PRE || state_ff.phase == PH_FETCH |-> state_ff.dma)
      else $error("DMA low during pre-display or fetch");

   a_fetch_line_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_FETCH |-> state_ff.line < LINE_W'(DISPLAY_ROWS))
      else $error("line counter past the display rows while fetching");

endmodule

// ----- verif/video_dma_frame_timer_tb.sv -----
// Self-checking testbench for video_dma_frame_timer: a directed table, then random
// request sequences whose responses are predicted in step and compared in order.
// Depends on vdft_pkg and the RTL of video_dma_frame_timer.
module video_dma_frame_timer_tb;
   import vdft_pkg::*;

   localparam int COLUMN_CYCLES = 14;
   localparam int DISPLAY_ROWS  = 128;
   localparam int FRAME_LINES   = 256;
   localparam int FETCH_CYCLES  = 8;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int DIR_ROWS     = 23;

   typedef struct packed {
      logic             irq;
      logic             fetch;
      logic [ROW_W-1:0] row;
      logic             dma;
      logic             vsync;
   } frame_event_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CYC_W-1:0] cyc;
      logic             known;
      logic             irq;
      logic             fetch;
      logic [ROW_W-1:0] row;
      logic             dma;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op = OP_ADVANCE;
   logic [CYC_W-1:0]    req_cycles = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_irq_pulse;
   logic                rsp_row_fetch;
   logic [ROW_W-1:0]    rsp_fetch_row;
   logic                rsp_dma_active;
   logic                rsp_vsync;

   // timer state as predicted
   phase_type                  tm_phase = PH_OFF;
   logic signed [BUDGET_W-1:0] tm_budget = '0;
   logic [LINE_W-1:0]          tm_line = '0;
   logic                       tm_dma = 1'b0;

   frame_event_type frame_event_q [$];
   dir_row_type     dir_tab [0:DIR_ROWS-1];

   int  mismatches = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   int  req_gap_pct = 0;
   int  rsp_gap_pct = 0;
   int  stall_left = 0;
   logic hold_req = 1'b0;
   logic hold_taken = 1'b0;

   video_dma_frame_timer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_cycles     (req_cycles),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_irq_pulse  (rsp_irq_pulse),
      .rsp_row_fetch  (rsp_row_fetch),
      .rsp_fetch_row  (rsp_fetch_row),
      .rsp_dma_active (rsp_dma_active),
      .rsp_vsync      (rsp_vsync)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [BUDGET_W-1:0] clamp16(int v);
      logic signed [BUDGET_W-1:0] r;
      if (v < -32768) begin
         r = -16'sd32768;
      end else if (v > 32767) begin
         r = 16'sd32767;
      end else begin
         r = v[BUDGET_W-1:0];
      end
      return r;
   endfunction

   // Advance the predicted timer by one request and return the response it causes.
   function automatic frame_event_type frame_step(logic [OP_W-1:0] op, logic [CYC_W-1:0] cyc);
      frame_event_type ev;
      ev = '0;
      case (op)
         OP_START: tm_phase = PH_ARMED;
         OP_STOP:  tm_phase = PH_OFF;
         OP_ADVANCE: begin
            case (tm_phase)
               PH_ARMED: begin
                  tm_budget = clamp16(COLUMN_CYCLES - int'(cyc));
                  tm_phase  = PH_PRE;
                  ev.irq    = 1'b1;
                  tm_dma    = 1'b1;
               end
               PH_PRE: begin
                  tm_budget = clamp16(int'(tm_budget) - int'(cyc));
                  if (tm_budget < 0) begin
                     tm_line   = '0;
                     tm_phase  = PH_FETCH;
                     tm_budget = clamp16(int'(tm_budget) + COLUMN_CYCLES);
                  end
               end
               PH_FETCH: begin
                  tm_budget = clamp16(int'(tm_budget) - int'(cyc));
                  if (tm_budget < 0) begin
                     ev.fetch  = 1'b1;
                     ev.row    = tm_line[ROW_W-1:0];
                     tm_budget = clamp16(int'(tm_budget) + (COLUMN_CYCLES - FETCH_CYCLES));
                     tm_line   = tm_line + LINE_W'(1);
                     if (tm_line >= LINE_W'(DISPLAY_ROWS)) begin
                        tm_dma    = 1'b0;
                        tm_budget = clamp16(int'(tm_budget) + 2 * COLUMN_CYCLES);
                        tm_phase  = PH_BLANK_A;
                     end
                  end
               end
               PH_BLANK_A, PH_BLANK_B: begin
                  tm_budget = clamp16(int'(tm_budget) - int'(cyc));
                  if (tm_budget < 0) begin
                     tm_dma    = (tm_phase == PH_BLANK_A);
                     tm_budget = clamp16(int'(tm_budget) + COLUMN_CYCLES);
                     tm_phase  = (tm_phase == PH_BLANK_A) ? PH_BLANK_B : PH_BLANK_A;
                     tm_line   = tm_line + LINE_W'(1);
                     if (tm_line >= LINE_W'(FRAME_LINES)) begin
                        tm_phase = PH_ARMED;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      ev.dma   = tm_dma;
      ev.vsync = ~tm_dma;
      return ev;
   endfunction

   task automatic note_mismatch(string what, int exp_v, int got_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %s: expected %0d, got %0d (cycle %0d)", what, exp_v, got_v,
                  cycle_count);
      end
   endtask

   // Offer one request, hold it until accepted, then record its expected response.
   task automatic offer(logic [OP_W-1:0] op, logic [CYC_W-1:0] cyc,
                        logic known, frame_event_type typed);
      frame_event_type ev;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_cycles <= cyc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ev = frame_step(op, cyc);
      frame_event_q.push_back(known ? typed : ev);
      items_sent++;
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic offer_advance();
      int r;
      logic [CYC_W-1:0] cyc;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         cyc = CYC_W'($urandom_range(0, 15));
      end else if (r < 35) begin
         cyc = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      end else begin
         cyc = CYC_W'($urandom_range(0, 63));
      end
      offer(OP_ADVANCE, cyc, 1'b0, '0);
   endtask

   // Receiver: random stall bursts, plus one long hold requested by the sender.
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         stall_left <= HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_gap_pct > 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      frame_event_type exp_ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_event_q.size() == 0) begin
            note_mismatch("unexpected response, irq", -1, int'(rsp_irq_pulse));
         end else begin
            exp_ev = frame_event_q.pop_front();
            if (rsp_irq_pulse !== exp_ev.irq) begin
               note_mismatch("irq_pulse", int'(exp_ev.irq), int'(rsp_irq_pulse));
            end
            if (rsp_row_fetch !== exp_ev.fetch) begin
               note_mismatch("row_fetch", int'(exp_ev.fetch), int'(rsp_row_fetch));
            end
            if (rsp_fetch_row !== exp_ev.row) begin
               note_mismatch("fetch_row", int'(exp_ev.row), int'(rsp_fetch_row));
            end
            if (rsp_dma_active !== exp_ev.dma) begin
               note_mismatch("dma_active", int'(exp_ev.dma), int'(rsp_dma_active));
            end
            if (rsp_vsync !== exp_ev.vsync) begin
               note_mismatch("vsync", int'(exp_ev.vsync), int'(rsp_vsync));
            end
         end
      end
   end

   initial begin
      frame_event_type typed;
      int chunk;
      int run_len;
      int r;

      // op, cycles, known, irq, fetch, row, dma
      dir_tab = '{
         '{OP_ADVANCE, 6'd0,  1'b1, 1'b0, 1'b0, 7'd0, 1'b0},  // advance while off
         '{OP_ADVANCE, 6'd63, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_UNUSED,  6'd63, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},  // unused op code
         '{OP_STOP,    6'd42, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_START,   6'd63, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_ADVANCE, 6'd63, 1'b1, 1'b1, 1'b0, 7'd0, 1'b1},  // interrupt, DMA up
         '{OP_ADVANCE, 6'd0,  1'b1, 1'b0, 1'b0, 7'd0, 1'b1},  // into fetching
         '{OP_ADVANCE, 6'd0,  1'b1, 1'b0, 1'b1, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd0,  1'b1, 1'b0, 1'b1, 7'd1, 1'b1},
         '{OP_UNUSED,  6'd21, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1},
         '{OP_STOP,    6'd21, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1},  // stop keeps DMA level
         '{OP_ADVANCE, 6'd63, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1},
         '{OP_START,   6'd0,  1'b1, 1'b0, 1'b0, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd0,  1'b1, 1'b1, 1'b0, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd14, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1},  // budget reaches zero
         '{OP_ADVANCE, 6'd1,  1'b1, 1'b0, 1'b0, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd13, 1'b1, 1'b0, 1'b0, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd1,  1'b1, 1'b0, 1'b1, 7'd0, 1'b1},
         '{OP_ADVANCE, 6'd42, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_ADVANCE, 6'd21, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_START,   6'd0,  1'b0, 1'b0, 1'b0, 7'd0, 1'b0},  // re-arm mid-frame
         '{OP_ADVANCE, 6'd7,  1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
         '{OP_STOP,    6'd0,  1'b0, 1'b0, 1'b0, 7'd0, 1'b0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct = 20;
      rsp_gap_pct = 20;
      for (int i = 0; i < DIR_ROWS; i++) begin
         typed.irq   = dir_tab[i].irq;
         typed.fetch = dir_tab[i].fetch;
         typed.row   = dir_tab[i].row;
         typed.dma   = dir_tab[i].dma;
         typed.vsync = ~dir_tab[i].dma;
         offer(dir_tab[i].op, dir_tab[i].cyc, dir_tab[i].known, typed);
      end

      items_sent = 0;
      chunk = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < RANDOM_ITEMS - QUIET_TAIL) begin
            r = $urandom_range(0, 2);
            req_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
            rsp_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
         end
         if (chunk == 1) begin
            hold_req <= 1'b1;
            req_gap_pct = 0;
         end

         // frame run: arm, then mostly advances with occasional noise
         offer(OP_START, CYC_W'($urandom_range(0, 63)), 1'b0, '0);
         run_len = $urandom_range(40, 450);
         for (int k = 0; k < run_len && items_sent < RANDOM_ITEMS; k++) begin
            if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
            r = $urandom_range(0, 199);
            if (r < 2) begin
               offer(OP_UNUSED, CYC_W'($urandom_range(0, 63)), 1'b0, '0);
            end else if (r < 3) begin
               offer(OP_START, CYC_W'($urandom_range(0, 63)), 1'b0, '0);
            end else if (r < 4) begin
               offer(OP_STOP, CYC_W'($urandom_range(0, 63)), 1'b0, '0);
            end else begin
               offer_advance();
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            offer(OP_STOP, CYC_W'($urandom_range(0, 63)), 1'b0, '0);
            repeat ($urandom_range(1, 4)) offer_advance();
         end

         // drain completely once before going on
         if (chunk == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (frame_event_q.size() != 0) @(posedge clock);
         end
         chunk++;
      end

      req_valid <= 1'b0;
      while (frame_event_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/vdft_pkg.sv
rtl/vdft_step.sv
rtl/video_dma_frame_timer.sv
verif/video_dma_frame_timer_tb.sv
